// File: hw/rtl/sem_pkg.sv
package sem_pkg;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int FW_W    = 11;
    localparam int GRAD_W  = 10;
    localparam int SQ_W    = 2 * GRAD_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DEPTH   = 1 << COL_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0]  WIDTH_MIN    = 11'd7;
    localparam logic [FW_W-1:0]  WIDTH_MAX    = 11'd1024;
    localparam logic [ROW_W-1:0] HEIGHT_MIN   = 12'd7;
    localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd256;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd256;
    localparam logic [ROW_W-1:0] BORDER       = 12'd3;

    localparam logic [SUM_W-1:0] SAT_SUM  = 21'd65025;
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic              start;
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
    } t_mag_req;

endpackage

// File: hw/rtl/sem_mag.sv
module sem_mag (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sem_pkg::t_mag_req     i_req,
    output logic                  o_done,
    output sem_pkg::t_pix         o_root
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ROOT
    } t_state;

    t_state                         r_state;
    logic [sem_pkg::GRAD_W-1:0]     r_ax;
    logic [sem_pkg::GRAD_W-1:0]     r_ay;
    logic [sem_pkg::SUM_W-1:0]      r_sum;
    logic [2:0]                     r_bit;
    sem_pkg::t_pix                  r_root;
    logic                           r_done;

    sem_pkg::t_pix                  n_trial;
    logic [2*sem_pkg::PIX_W-1:0]    n_trial_sq;
    logic [sem_pkg::SQ_W-1:0]       n_sq;

    // One multiplier serves both squares: ax in the SQX state, ay in the SQY state that follows.
    always_comb begin
        n_sq       = (r_state == S_SQX) ? r_ax * r_ax : r_ay * r_ay;
        n_trial    = r_root | (sem_pkg::t_pix'(1) << r_bit);
        n_trial_sq = n_trial * n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_bit   <= '0;
            r_root  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ax    <= i_req.ax;
                        r_ay    <= i_req.ay;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sum   <= sem_pkg::SUM_W'(n_sq);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum   <= r_sum + sem_pkg::SUM_W'(n_sq);
                    r_bit   <= 3'd7;
                    r_root  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_sum >= sem_pkg::SAT_SUM) begin
                        r_root  <= sem_pkg::EDGE_MAX;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (sem_pkg::SUM_W'(n_trial_sq) <= r_sum) begin
                            r_root <= n_trial;
                        end
                        r_bit <= r_bit - 3'd1;
                        if (r_bit == 3'd0) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("magnitude unit started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("magnitude done held for more than one cycle");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE)
        else $error("magnitude done while still iterating");
`endif

endmodule

// File: hw/rtl/sobel_edge_magnitude_3x3.sv
// A pixel that gives no word goes from the read state back to idle; a zero-border word goes
// through the put state to the output register; an interior word goes through the gradient,
// magnitude (ending early on saturation) and put states. A new pixel is taken only in idle,
// once the last is through; the interior path is set by the shared squaring multiplier and
// the eight-step bitwise square root. Reset clears counters and the window and returns both
// sizes to 256, not the line stores; a size write restarts the frame at row and column 0.
module sobel_edge_magnitude_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sem_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sem_pkg::ROW_W-1:0]        o_out_row,
    output logic [sem_pkg::COL_W-1:0]        o_out_col,
    output logic [sem_pkg::PIX_W-1:0]        o_edge_value,
    input  logic                             i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_GRAD,
        S_MAG,
        S_PUT
    } t_state;

    t_state                        r_state;
    logic [sem_pkg::FW_W-1:0]      r_frame_width;
    logic [sem_pkg::ROW_W-1:0]     r_frame_height;
    logic [sem_pkg::ROW_W-1:0]     r_row_count;
    logic [sem_pkg::COL_W-1:0]     r_col_count;
    logic [sem_pkg::COL_W-1:0]     r_addr;
    sem_pkg::t_pix                 r_px;
    sem_pkg::t_pix                 r_win [3][3];
    sem_pkg::t_pix                 r_up_q;
    sem_pkg::t_pix                 r_lo_q;
    logic [sem_pkg::ROW_W-1:0]     r_orow;
    logic [sem_pkg::COL_W-1:0]     r_ocol;
    sem_pkg::t_pix                 r_val;
    logic                          r_out_valid;
    logic [sem_pkg::ROW_W-1:0]     r_out_row;
    logic [sem_pkg::COL_W-1:0]     r_out_col;
    sem_pkg::t_pix                 r_out_val;

    sem_pkg::t_pix                 mem_up [sem_pkg::DEPTH];
    sem_pkg::t_pix                 mem_lo [sem_pkg::DEPTH];

    logic [sem_pkg::FW_W-1:0]      n_width;
    logic [sem_pkg::ROW_W-1:0]     n_height;
    logic [sem_pkg::COL_W-1:0]     n_addr;
    logic [sem_pkg::ROW_W-1:0]     n_row;
    logic [sem_pkg::FW_W-1:0]      n_col_inc;
    logic [sem_pkg::ROW_W:0]       n_row_inc;
    logic                          n_emit;
    logic                          n_inner;
    logic [sem_pkg::ROW_W-1:0]     n_orow;
    logic [sem_pkg::COL_W-1:0]     n_ocol;
    logic [sem_pkg::GRAD_W-1:0]    n_xp, n_xn, n_yp, n_yn;
    logic                          n_accept;
    logic                          n_mem_we;
    logic                          n_out_take;
    sem_pkg::t_mag_req             n_req;
    logic                          mag_done;
    sem_pkg::t_pix                 mag_root;

    always_comb begin
        n_width = r_frame_width;
        if (r_frame_width < sem_pkg::WIDTH_MIN) begin
            n_width = sem_pkg::WIDTH_MIN;
        end else if (r_frame_width > sem_pkg::WIDTH_MAX) begin
            n_width = sem_pkg::WIDTH_MAX;
        end
        n_height = (r_frame_height < sem_pkg::HEIGHT_MIN) ? sem_pkg::HEIGHT_MIN
                                                          : r_frame_height;

        n_addr = r_col_count;
        if ({1'b0, r_col_count} >= n_width) begin
            n_addr = sem_pkg::COL_W'(n_width - sem_pkg::FW_W'(1));
        end
        n_row = (r_row_count >= n_height) ? n_height - sem_pkg::ROW_W'(1) : r_row_count;

        n_col_inc = {1'b0, r_addr} + sem_pkg::FW_W'(1);
        n_row_inc = {1'b0, n_row} + (sem_pkg::ROW_W + 1)'(1);

        n_orow  = n_row - sem_pkg::ROW_W'(1);
        n_ocol  = r_addr - sem_pkg::COL_W'(1);
        n_emit  = (n_row >= sem_pkg::ROW_W'(2)) && (r_addr >= sem_pkg::COL_W'(2));
        n_inner = (n_orow >= sem_pkg::BORDER)
               && (n_orow < n_height - sem_pkg::BORDER)
               && ({1'b0, n_ocol} >= sem_pkg::FW_W'(sem_pkg::BORDER))
               && ({1'b0, n_ocol} < n_width - sem_pkg::FW_W'(sem_pkg::BORDER));

        // Each gradient is the difference of two weighted column or row sums.
        n_xp = {2'b0, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b0, r_win[2][2]};
        n_xn = {2'b0, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b0, r_win[2][0]};
        n_yp = {2'b0, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b0, r_win[2][2]};
        n_yn = {2'b0, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b0, r_win[0][2]};

        n_req.start = (r_state == S_GRAD);
        n_req.ax    = (n_xp >= n_xn) ? n_xp - n_xn : n_xn - n_xp;
        n_req.ay    = (n_yp >= n_yn) ? n_yp - n_yn : n_yn - n_yp;

        n_accept   = i_valid && o_ready;
        n_mem_we   = (r_state == S_RD);
        n_out_take = r_out_valid && i_ready;
    end

    assign o_ready = (r_state == S_IDLE);

    // The line stores are read when a pixel is taken and written back in the following read state.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_up_q <= mem_up[n_addr];
            r_lo_q <= mem_lo[n_addr];
        end
        if (n_mem_we) begin
            mem_up[r_addr] <= r_lo_q;
            mem_lo[r_addr] <= r_px;
        end
    end

    sem_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_done  (mag_done),
        .o_root  (mag_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_width  <= sem_pkg::WIDTH_RESET;
            r_frame_height <= sem_pkg::HEIGHT_RESET;
            r_row_count    <= '0;
            r_col_count    <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            // In the put state a taken word is replaced by the new one below.
            if (n_out_take && r_state != S_PUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_addr  <= n_addr;
                        r_px    <= i_pixel_in;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= r_up_q;
                    r_win[1][2] <= r_lo_q;
                    r_win[2][2] <= r_px;
                    if (n_col_inc >= n_width) begin
                        r_col_count <= '0;
                        r_row_count <= (n_row_inc >= {1'b0, n_height})
                                       ? '0 : n_row_inc[sem_pkg::ROW_W-1:0];
                    end else begin
                        r_col_count <= n_col_inc[sem_pkg::COL_W-1:0];
                        r_row_count <= n_row;
                    end
                    r_orow <= n_orow;
                    r_ocol <= n_ocol;
                    r_val  <= '0;
                    if (!n_emit) begin
                        r_state <= S_IDLE;
                    end else if (n_inner) begin
                        r_state <= S_GRAD;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_GRAD: begin
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    if (mag_done) begin
                        r_val   <= mag_root;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_orow;
                        r_out_col   <= r_ocol;
                        r_out_val   <= r_val;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sem_pkg::CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[sem_pkg::FW_W-1:0];
                        r_row_count   <= '0;
                        r_col_count   <= '0;
                    end
                    sem_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[sem_pkg::ROW_W-1:0];
                        r_row_count    <= '0;
                        r_col_count    <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_edge_value = r_out_val;

`ifndef SYNTH
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_mem_we |-> !n_accept)
        else $error("line store written in the cycle of a new read");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col_count} < n_width)
        else $error("column counter beyond the frame width");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> !o_ready)
        else $error("second pixel taken while one is in flight");

    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && (!r_out_valid || i_ready)) |=> o_valid)
        else $error("finished word not presented");
`endif

endmodule

// File: sim/sem_edge_checker.sv
module sem_edge_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_valid,
    input  logic                          i_pix_ready,
    input  logic [sem_pkg::PIX_W-1:0]     i_pix,
    input  logic                          i_word_valid,
    input  logic                          i_word_ready,
    input  logic [sem_pkg::ROW_W-1:0]     i_word_row,
    input  logic [sem_pkg::COL_W-1:0]     i_word_col,
    input  logic [sem_pkg::PIX_W-1:0]     i_word_edge,
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] mag;
    } t_edge_word;

    t_pix             upper_line [DEPTH];
    t_pix             lower_line [DEPTH];
    t_pix             win [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [FW_W-1:0]  width_reg;
    logic [ROW_W-1:0] height_reg;
    t_edge_word       edge_words_due [$];

    function automatic int unsigned line_width();
        if (width_reg < WIDTH_MIN) return WIDTH_MIN;
        if (width_reg > WIDTH_MAX) return WIDTH_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        if (height_reg < HEIGHT_MIN) return HEIGHT_MIN;
        return height_reg;
    endfunction

    function automatic t_pix root_clamped(int unsigned sq);
        int unsigned root;
        if (sq >= SAT_SUM) return EDGE_MAX;
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        return t_pix'(root);
    endfunction

    function automatic t_pix window_magnitude();
        int w [3][3];
        int gx;
        int gy;
        foreach (win[i, j]) w[i][j] = int'(win[i][j]);
        gx = (w[0][2] + 2 * w[1][2] + w[2][2]) - (w[0][0] + 2 * w[1][0] + w[2][0]);
        gy = (w[2][0] + 2 * w[2][1] + w[2][2]) - (w[0][0] + 2 * w[0][1] + w[0][2]);
        return root_clamped(gx * gx + gy * gy);
    endfunction

    task automatic log_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    // Shift the window by one column; from row and column 2 on, queue the center word.
    task automatic advance_stream(input t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned orow;
        int unsigned ocol;
        t_pix        top;
        t_pix        mid;
        t_edge_word  word;
        w = line_width();
        h = frame_rows();
        r = row_pos;
        c = col_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        top = upper_line[c];
        mid = lower_line[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        upper_line[c] = mid;
        lower_line[c] = px;
        if (r >= 2 && c >= 2) begin
            orow = r - 1;
            ocol = c - 1;
            word.row = ROW_W'(orow);
            word.col = COL_W'(ocol);
            if (orow >= BORDER && orow < h - BORDER && ocol >= BORDER && ocol < w - BORDER) begin
                word.mag = window_magnitude();
            end else begin
                word.mag = '0;
            end
            edge_words_due.push_back(word);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_word();
        t_edge_word want;
        if (edge_words_due.size() == 0) begin
            log_mismatch($sformatf("unexpected word row %0d col %0d edge %0d",
                                   i_word_row, i_word_col, i_word_edge));
            return;
        end
        want = edge_words_due.pop_front();
        if (i_word_row !== want.row)
            log_mismatch($sformatf("row got %0d expected %0d", i_word_row, want.row));
        if (i_word_col !== want.col)
            log_mismatch($sformatf("col got %0d expected %0d (row %0d)",
                                   i_word_col, want.col, want.row));
        if (i_word_edge !== want.mag)
            log_mismatch($sformatf("edge at row %0d col %0d got %0d expected %0d",
                                   want.row, want.col, i_word_edge, want.mag));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            row_pos = 0;
            col_pos = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            edge_words_due.delete();
        end else begin
            // Only the two size registers restart the frame; other indexes are ignored.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[FW_W-1:0];
                    row_pos = 0;
                    col_pos = 0;
                end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[ROW_W-1:0];
                    row_pos = 0;
                    col_pos = 0;
                end
            end
            if (i_word_valid && i_word_ready) check_word();
            if (i_pix_valid && i_pix_ready) advance_stream(i_pix);
        end
        o_pending <= edge_words_due.size();
    end

endmodule

// File: sim/tb_sobel_edge_magnitude_3x3.sv
module tb_sobel_edge_magnitude_3x3;
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_FLAT, PIX_RAMP} t_pix_mode;

    localparam int PIXEL_BUDGET  = 400;
    localparam int CYCLE_LIMIT   = 700000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_GAP       = 6;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 pix_valid  = 1'b0;
    t_pix                 pix_data   = '0;
    logic                 word_ready = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data   = '0;

    logic                 pix_ready;
    logic                 word_valid;
    logic [ROW_W-1:0]     word_row;
    logic [COL_W-1:0]     word_col;
    logic [PIX_W-1:0]     word_edge;

    int                   fail_count;
    int                   words_pending;
    int unsigned          cycle_count = 0;
    logic                 calm_send   = 1'b0;
    int unsigned          eff_w;
    int unsigned          eff_h;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    sobel_edge_magnitude_3x3 i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (pix_valid),
        .o_ready      (pix_ready),
        .i_pixel_in   (pix_data),
        .o_valid      (word_valid),
        .i_ready      (word_ready),
        .o_out_row    (word_row),
        .o_out_col    (word_col),
        .o_edge_value (word_edge),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    sem_edge_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pix        (pix_data),
        .i_word_valid (word_valid),
        .i_word_ready (word_ready),
        .i_word_row   (word_row),
        .i_word_col   (word_col),
        .i_word_edge  (word_edge),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Valid stays high across back-to-back pixels; between pixels it only drops when a gap is drawn.
    task automatic send_pixel(input t_pix px);
        int gap;
        gap = calm_send ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge i_clk);
        while (!pix_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Wait for every expected word, then let any word-less pixel drain out of the pipe.
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(1025, 4095)));
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_FRAME_WIDTH, w_val);
            write_reg(CFG_FRAME_HEIGHT, h_val);
        end else begin
            write_reg(CFG_FRAME_HEIGHT, h_val);
            write_reg(CFG_FRAME_WIDTH, w_val);
        end
        cfg_we <= 1'b0;
        eff_w = (w_val[FW_W-1:0] < WIDTH_MIN) ? WIDTH_MIN :
                (w_val[FW_W-1:0] > WIDTH_MAX) ? WIDTH_MAX : w_val[FW_W-1:0];
        eff_h = (h_val < HEIGHT_MIN) ? HEIGHT_MIN : h_val;
    endtask

    function automatic t_pix make_pixel(t_pix_mode mode, int unsigned idx, t_pix base);
        int unsigned col;
        int unsigned row;
        col = idx % eff_w;
        row = idx / eff_w;
        case (mode)
            PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
            PIX_FLAT:    return base + t_pix'($urandom_range(0, 15));
            PIX_RAMP:    return t_pix'(col * 23 + row * 9) + t_pix'($urandom_range(0, 3));
            default:     return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : word_sink
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm = 1'b0;
        forever begin
            if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                word_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            word_ready <= 1'b1;
            @(posedge i_clk);
            while (!word_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        int               n;
        int               pause_at;
        int               roll;
        int               sent;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        t_pix_mode        mode;
        t_pix             base;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both sizes below the minimum clamp to 7x7. Dark left half against a bright
        // right half drives the single interior position into saturation.
        set_frame(12'd3, 12'd0);
        for (int i = 0; i < 33; i++) send_pixel((i % 7 >= 3) ? 8'hFF : 8'h00);
        settle();

        sent = 0;
        while (sent < PIXEL_BUDGET) begin
            roll = $urandom_range(0, 15);
            w_val = (roll < 2) ? CFG_W'($urandom_range(0, 6)) :
                    (roll < 5) ? CFG_W'($urandom_range(21, 48)) : CFG_W'($urandom_range(7, 20));
            roll = $urandom_range(0, 15);
            h_val = (roll < 2)  ? CFG_W'($urandom_range(0, 6)) :
                    (roll == 2) ? CFG_W'(4095) :
                    (roll < 5)  ? CFG_W'($urandom_range(13, 40)) : CFG_W'($urandom_range(7, 12));
            set_frame(w_val, h_val);
            if (eff_w * eff_h <= 300) begin
                n = $urandom_range(eff_w * eff_h / 2, eff_w * eff_h + 2 * eff_w);
            end else begin
                n = $urandom_range(3 * eff_w, 8 * eff_w);
            end
            mode = t_pix_mode'($urandom_range(0, 3));
            base = t_pix'($urandom);
            calm_send = ($urandom_range(0, 3) == 0);
            pause_at = ($urandom_range(0, 5) == 0) ? n / 2 : -1;
            for (int i = 0; i < n; i++) begin
                // A write to an unused index mid-frame must not restart the frame.
                if (i == pause_at) begin
                    settle();
                    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                              CFG_W'($urandom));
                    cfg_we <= 1'b0;
                end
                send_pixel(make_pixel(mode, i, base));
            end
            settle();
            sent += n;
        end

        // Widest line: the upper data bit is dropped, leaving exactly 1024. The run crosses
        // the last column into the next row.
        set_frame(12'hC00, 12'd7);
        calm_send = 1'b0;
        n = eff_w + $urandom_range(20, 60);
        for (int i = 0; i < n; i++) send_pixel(make_pixel(PIX_NOISE, i, 8'h00));
        settle();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_mag.sv
hw/rtl/sobel_edge_magnitude_3x3.sv
sim/sem_edge_checker.sv
sim/tb_sobel_edge_magnitude_3x3.sv
